FILE: hw/rtl/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg
// types and constants shared by the quaternion to euler angle pipeline
// ----------------------------------------------------------------------------
package q2e_pkg;

	typedef struct packed {
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
	} quat_req_t;

	typedef struct packed {
		logic signed [14:0] pitch_angle;
		logic signed [15:0] yaw_angle;
		logic signed [15:0] roll_angle;
		logic               zero_length;
	} euler_req_t;

	// cordic datapath width, operands up to about 2^34 grow by < 2x
	localparam int unsigned CW = 38;
	// angle accumulator width, +-2^33 covers 18000*2^16 with margin
	localparam int unsigned AW = 34;
	localparam int unsigned TABLE_LEN = 24;
	localparam logic signed [AW-1:0] QUARTER_ACC = AW'(64'sd589824000);
	localparam logic signed [15:0] HALF_TURN = 16'sd18000;
	localparam logic signed [15:0] QUARTER_TURN = 16'sd9000;
	localparam logic signed [15:0] PITCH_LIMIT = 16'sd8919;

	// atan(2^-i) in hundredths of a degree times 2^16
	function automatic logic signed [AW-1:0] atan_tab(input logic [4:0] i);
		logic signed [AW-1:0] v;
		unique case (i)
			5'd0: v = AW'(64'sd294912000);
			5'd1: v = AW'(64'sd174096719);
			5'd2: v = AW'(64'sd91987925);
			5'd3: v = AW'(64'sd46694507);
			5'd4: v = AW'(64'sd23437865);
			5'd5: v = AW'(64'sd11730358);
			5'd6: v = AW'(64'sd5866610);
			5'd7: v = AW'(64'sd2933484);
			5'd8: v = AW'(64'sd1466764);
			5'd9: v = AW'(64'sd733385);
			5'd10: v = AW'(64'sd366693);
			5'd11: v = AW'(64'sd183346);
			5'd12: v = AW'(64'sd91673);
			5'd13: v = AW'(64'sd45837);
			5'd14: v = AW'(64'sd22918);
			5'd15: v = AW'(64'sd11459);
			5'd16: v = AW'(64'sd5730);
			5'd17: v = AW'(64'sd2865);
			5'd18: v = AW'(64'sd1432);
			5'd19: v = AW'(64'sd716);
			5'd20: v = AW'(64'sd358);
			5'd21: v = AW'(64'sd179);
			5'd22: v = AW'(64'sd90);
			5'd23: v = AW'(64'sd45);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: hw/rtl/q2e_cordic_cell.sv
// ----------------------------------------------------------------------------
// q2e_cordic_cell
// one registered vectoring micro-rotation for the three angle lanes
// ----------------------------------------------------------------------------
module q2e_cordic_cell #(
	parameter int unsigned SHIFT = 0
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic signed [2:0][q2e_pkg::CW-1:0]     x_in,
	input  logic signed [2:0][q2e_pkg::CW-1:0]     y_in,
	input  logic signed [2:0][q2e_pkg::AW-1:0]     acc_in,
	input  logic                                   vld_in,
	output logic signed [2:0][q2e_pkg::CW-1:0]     x_q,
	output logic signed [2:0][q2e_pkg::CW-1:0]     y_q,
	output logic signed [2:0][q2e_pkg::AW-1:0]     acc_q,
	output logic                                   vld_q
);
	localparam logic signed [q2e_pkg::AW-1:0] ANG = q2e_pkg::atan_tab(5'(SHIFT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				// lane selects are unsigned, so signedness is restored per lane
				// arithmetic shift is floor division by 2^SHIFT
				if ($signed(y_in[l]) > 0) begin
					x_q[l]   <= $signed(x_in[l]) + ($signed(y_in[l]) >>> SHIFT);
					y_q[l]   <= $signed(y_in[l]) - ($signed(x_in[l]) >>> SHIFT);
					acc_q[l] <= acc_in[l] + ANG;
				end else begin
					x_q[l]   <= $signed(x_in[l]) - ($signed(y_in[l]) >>> SHIFT);
					y_q[l]   <= $signed(y_in[l]) + ($signed(x_in[l]) >>> SHIFT);
					acc_q[l] <= acc_in[l] - ANG;
				end
			end
		end
	end
endmodule

FILE: hw/rtl/q2e_isqrt_cell.sv
// ----------------------------------------------------------------------------
// q2e_isqrt_cell
// one registered digit of a restoring integer square root, 64 bit radicand
// ----------------------------------------------------------------------------
module q2e_isqrt_cell #(
	parameter int unsigned STEP = 0
) (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] rem_in,
	input  logic [32:0] root_in,
	output logic [63:0] rem_q,
	output logic [32:0] root_q
);
	// trial is (4*root + 1) << 2*(31-STEP), root held unshifted
	localparam int unsigned SH = 2 * (31 - STEP);
	logic [65:0] trial;

	always_comb begin
		trial = ({31'd0, root_in, 2'b01}) << SH;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if ({2'b00, rem_in} >= trial) begin
				rem_q  <= rem_in - trial[63:0];
				root_q <= {root_in[31:0], 1'b1};
			end else begin
				rem_q  <= rem_in;
				root_q <= {root_in[31:0], 1'b0};
			end
		end
	end
endmodule

FILE: hw/rtl/quaternion_to_euler_angles.sv
// throughput: one request per cycle while no waiting result is stalled, the whole chain advances in lockstep
// a waiting result freezes every stage; in_stall follows out_stall then
// the 32 root digit cells and ROTATION_STAGES cordic cells set the depth
// reset: arst_n clears all valid flags, payload registers are not reset
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// pipelined quaternion to pitch/yaw/roll conversion in hundredths of a degree
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles #(
	parameter int unsigned ROTATION_STAGES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  q2e_pkg::quat_req_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output q2e_pkg::euler_req_t  out_data
);
	localparam int unsigned CW = q2e_pkg::CW;
	localparam int unsigned AW = q2e_pkg::AW;
	localparam int unsigned NR = ROTATION_STAGES;
	localparam int unsigned SQ = 32;
	localparam logic signed [CW-1:0] PITCH_CLAMP = CW'(q2e_pkg::QUARTER_TURN);

	// whole pipe moves when the output register is free or being drained
	logic en;
	assign en = !out_valid || !out_stall;
	assign in_stall = !en;

	// stage 1: products, exact Q2.30
	logic               v_s1;
	logic signed [31:0] ww_s1, xx_s1, yy_s1, zz_s1;
	logic signed [31:0] yz_s1, wx_s1, wy_s1, xz_s1, wz_s1, xy_s1;
	logic               zero_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ww_s1 <= in_data.quat_w * in_data.quat_w;
			xx_s1 <= in_data.quat_x * in_data.quat_x;
			yy_s1 <= in_data.quat_y * in_data.quat_y;
			zz_s1 <= in_data.quat_z * in_data.quat_z;
			yz_s1 <= in_data.quat_y * in_data.quat_z;
			wx_s1 <= in_data.quat_w * in_data.quat_x;
			wy_s1 <= in_data.quat_w * in_data.quat_y;
			xz_s1 <= in_data.quat_x * in_data.quat_z;
			wz_s1 <= in_data.quat_w * in_data.quat_z;
			xy_s1 <= in_data.quat_x * in_data.quat_y;
			zero_s1 <= (in_data.quat_w == '0) && (in_data.quat_x == '0) &&
				(in_data.quat_y == '0) && (in_data.quat_z == '0);
		end
	end

	// stage 2: norm, d, hemisphere flip (negating w negates every w term)
	logic               v_s2, zero_s2;
	logic signed [33:0] n2_s2, d_s2, sy_s2, sr_s2;
	logic signed [35:0] cy_s2, cr_s2;
	logic signed [33:0] n2_c, d0_c, ad_c;
	logic               flip_c;

	always_comb begin
		n2_c = 34'(ww_s1) + 34'(xx_s1) + 34'(yy_s1) + 34'(zz_s1);
		d0_c = 34'(yz_s1) - 34'(wx_s1);
		ad_c = d0_c[33] ? -d0_c : d0_c;
		flip_c = (ad_c <<< 1) > n2_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s2 <= zero_s1;
			n2_s2   <= n2_c;
			d_s2    <= flip_c ? 34'(yz_s1) + 34'(wx_s1) : d0_c;
			sy_s2   <= (flip_c ? 34'(xz_s1) - 34'(wy_s1) : 34'(wy_s1) + 34'(xz_s1)) <<< 1;
			sr_s2   <= (flip_c ? 34'(xy_s1) - 34'(wz_s1) : 34'(wz_s1) + 34'(xy_s1)) <<< 1;
			cy_s2   <= 36'(n2_c) - (36'(34'(xx_s1) + 34'(yy_s1)) <<< 1);
			cr_s2   <= 36'(n2_c) - (36'(34'(xx_s1) + 34'(zz_s1)) <<< 1);
		end
	end

	// stage 3: pitch clamp test and sqrt operand halving
	logic               v_s3, zero_s3, clamp_s3, neg_s3;
	logic [33:0]        n_s3, s_s3;
	logic signed [33:0] sy_s3, sr_s3;
	logic signed [35:0] cy_s3, cr_s3;
	logic [34:0]        as2_c;
	logic [33:0]        n_c, s_c;

	always_comb begin
		as2_c = d_s2[33] ? 35'(-d_s2) << 1 : 35'(d_s2) << 1;
		n_c = n2_s2;
		s_c = as2_c[33:0];
		if (n2_s2[33:31] != 3'b000) begin
			n_c = n2_s2 >> 1;
			s_c = as2_c[34:1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s3  <= zero_s2;
			clamp_s3 <= (49'(as2_c) * 49'd10000) > (49'(n2_s2) * 49'd9999);
			neg_s3   <= !d_s2[33] && (d_s2 != '0);
			n_s3     <= n_c;
			s_s3     <= s_c;
			sy_s3 <= sy_s2; sr_s3 <= sr_s2; cy_s3 <= cy_s2; cr_s3 <= cr_s2;
		end
	end

	// stage 4: radicand (n-s)(n+s), under 2^64
	logic               v_s4, zero_s4, clamp_s4, neg_s4;
	logic [33:0]        s_s4;
	logic [63:0]        rad_s4;
	logic signed [33:0] sy_s4, sr_s4;
	logic signed [35:0] cy_s4, cr_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s4 <= zero_s3; clamp_s4 <= clamp_s3; neg_s4 <= neg_s3;
			s_s4    <= s_s3;
			rad_s4  <= 64'(n_s3 - s_s3) * 64'(n_s3 + s_s3);
			sy_s4 <= sy_s3; sr_s4 <= sr_s3; cy_s4 <= cy_s3; cr_s4 <= cr_s3;
		end
	end

	// root digit chain, side data delayed alongside
	typedef struct packed {
		logic               zero;
		logic               clamp;
		logic               neg;
		logic [33:0]        s;
		logic signed [33:0] sy;
		logic signed [33:0] sr;
		logic signed [35:0] cy;
		logic signed [35:0] cr;
	} side_t;

	logic [SQ:0][63:0] rem;
	logic [SQ:0][32:0] root;
	side_t [SQ:0]      side;
	logic [SQ:0]       sv;

	assign rem[0]  = rad_s4;
	assign root[0] = '0;
	assign sv[0]   = v_s4;
	assign side[0] = '{zero: zero_s4, clamp: clamp_s4, neg: neg_s4, s: s_s4,
		sy: sy_s4, sr: sr_s4, cy: cy_s4, cr: cr_s4};

	for (genvar g = 0; g < SQ; g++) begin : g_sqrt
		q2e_isqrt_cell #(.STEP(g)) u_cell (
			.clk    (clk),
			.en     (en),
			.rem_in (rem[g]),
			.root_in(root[g]),
			.rem_q  (rem[g+1]),
			.root_q (root[g+1])
		);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sv[g+1] <= 1'b0;
			else if (en) sv[g+1] <= sv[g];
		end
		always_ff @(posedge clk) begin
			if (en) side[g+1] <= side[g];
		end
	end

	// cordic pre-rotation into the right half plane, lanes pitch/yaw/roll
	logic signed [2:0][CW-1:0] px, py, cx_c, cy_c;
	logic signed [2:0][AW-1:0] ca_c;
	logic [2:0]                both0_c;
	logic                      v_s5, zero_s5, clamp_s5, neg_s5;
	logic [2:0]                both0_s5;
	logic signed [2:0][CW-1:0] x_s5, y_s5;
	logic signed [2:0][AW-1:0] a_s5;

	always_comb begin
		px[0] = CW'(signed'({1'b0, root[SQ][31:0]}));
		py[0] = CW'(signed'({1'b0, side[SQ].s}));
		px[1] = CW'(side[SQ].cy);
		py[1] = CW'(side[SQ].sy);
		px[2] = CW'(side[SQ].cr);
		py[2] = CW'(side[SQ].sr);
		for (int l = 0; l < 3; l++) begin
			both0_c[l] = (px[l] == '0) && (py[l] == '0);
			cx_c[l] = px[l];
			cy_c[l] = py[l];
			ca_c[l] = '0;
			// lane selects are unsigned, compare them as signed
			if ($signed(px[l]) < 0) begin
				if ($signed(py[l]) >= 0) begin
					cx_c[l] = py[l];
					cy_c[l] = -px[l];
					ca_c[l] = q2e_pkg::QUARTER_ACC;
				end else begin
					cx_c[l] = -py[l];
					cy_c[l] = px[l];
					ca_c[l] = -q2e_pkg::QUARTER_ACC;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= sv[SQ];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s5 <= side[SQ].zero; clamp_s5 <= side[SQ].clamp; neg_s5 <= side[SQ].neg;
			both0_s5 <= both0_c;
			x_s5 <= cx_c; y_s5 <= cy_c; a_s5 <= ca_c;
		end
	end

	// micro-rotation chain
	logic signed [NR:0][2:0][CW-1:0] rx, ry;
	logic signed [NR:0][2:0][AW-1:0] ra;
	logic [NR:0]                     rv;
	logic [NR:0][5:0]                rflag;

	assign rx[0] = x_s5;
	assign ry[0] = y_s5;
	assign ra[0] = a_s5;
	assign rv[0] = v_s5;
	assign rflag[0] = {zero_s5, clamp_s5, neg_s5, both0_s5};

	for (genvar g = 0; g < NR; g++) begin : g_rot
		q2e_cordic_cell #(.SHIFT(g)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.x_in  (rx[g]),
			.y_in  (ry[g]),
			.acc_in(ra[g]),
			.vld_in(rv[g]),
			.x_q   (rx[g+1]),
			.y_q   (ry[g+1]),
			.acc_q (ra[g+1]),
			.vld_q (rv[g+1])
		);
		always_ff @(posedge clk) begin
			if (en) rflag[g+1] <= rflag[g];
		end
	end

	// rounding, saturation, pitch sign, special cases
	logic signed [2:0][CW-1:0] ang_c;
	logic signed [CW-1:0]      pitch_c;
	logic                      f_zero, f_clamp, f_neg;
	logic [2:0]                f_both0;
	q2e_pkg::euler_req_t       res_c;

	always_comb begin
		{f_zero, f_clamp, f_neg, f_both0} = rflag[NR];
		for (int l = 0; l < 3; l++) begin
			// round half up, floor shift of the signed accumulator
			ang_c[l] = CW'(($signed(ra[NR][l]) + AW'(64'sd32768)) >>> 16);
			if (f_both0[l]) ang_c[l] = '0;
			else if ($signed(ang_c[l]) > CW'(q2e_pkg::HALF_TURN))
				ang_c[l] = CW'(q2e_pkg::HALF_TURN);
			else if ($signed(ang_c[l]) < -CW'(q2e_pkg::HALF_TURN))
				ang_c[l] = -CW'(q2e_pkg::HALF_TURN);
		end
		pitch_c = f_neg ? -ang_c[0] : ang_c[0];
		if (pitch_c > PITCH_CLAMP) pitch_c = PITCH_CLAMP;
		else if (pitch_c < -PITCH_CLAMP) pitch_c = -PITCH_CLAMP;
		if (f_clamp) pitch_c = f_neg ? -CW'(q2e_pkg::PITCH_LIMIT) : CW'(q2e_pkg::PITCH_LIMIT);
		res_c.pitch_angle = 15'(pitch_c);
		res_c.yaw_angle   = 16'(ang_c[1]);
		res_c.roll_angle  = 16'(ang_c[2]);
		res_c.zero_length = f_zero;
		if (f_zero) begin
			res_c = '0;
			res_c.zero_length = 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= rv[NR];
	end

	always_ff @(posedge clk) begin
		if (en) out_data <= res_c;
	end
endmodule
